// ===== design/prse_pkg.sv =====
// Package with the shared types, codes and defaults of the request slot enqueue block.
package prse_pkg;

    // Default sizes handed to the top level.
    localparam int NUM_CUBES_DEF      = 8;
    localparam int LINKS_PER_CUBE_DEF = 8;
    localparam int QUEUE_DEPTH_DEF    = 8;
    localparam int MAX_WORDS_DEF      = 32;

    // Configuration port shape and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_MASK   = 1'd1;
    localparam logic [3:0] QUEUE_DEPTH_RESET = 4'd8;

    // Packet word field positions.
    localparam int HDR_FLIT_LSB = 7;
    localparam int HDR_FLIT_MSB = 10;
    localparam int HDR_CUBE_MSB = 5;
    localparam int TAIL_LINK_LSB = 24;
    localparam int TAIL_LINK_MSB = 26;

    // Result status codes.
    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_STALL    = 2'd1;
    localparam logic [1:0] STATUS_NOT_HOST = 2'd2;
    localparam logic [1:0] STATUS_BAD      = 2'd3;

    // Input item kinds.
    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // One input beat.
    typedef struct packed {
        logic        kind;
        logic [63:0] word;
        logic [5:0]  release_cube;
        logic [2:0]  release_link;
        logic [2:0]  release_slot;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic [1:0] status;
        logic [5:0] cube_id;
        logic [2:0] link_id;
        logic [2:0] slot_index;
    } t_res_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_word;
        logic emit_hdr;
        logic emit_chk;
        logic row_read;
        logic scan_inc;
        logic emit_stall;
        logic emit_ok;
        logic rel_read;
        logic rel_write;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic hdr_bad;
        logic last_word;
        logic chk_fail;
        logic rel_ok;
        logic scan_end;
        logic scan_free;
        logic copy_done;
    } t_dp_status;

endpackage

// ===== design/prse_ctrl.sv =====
// Controller state machine that sequences staging, slot search, copy and release.
module prse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  prse_pkg::t_dp_status i_status,
    output prse_pkg::t_ctrl_cmd o_cmd,
    output logic                o_busy
);
    import prse_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COPY,
        S_REL
    } t_state;

    t_state    r_state, n_state;
    logic      r_busy;
    t_ctrl_cmd n_cmd;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_status.is_release) begin
                        if (i_status.rel_ok) begin
                            n_cmd.rel_read = 1'b1;
                            n_state        = S_REL;
                        end
                    end else if (i_status.hdr_bad) begin
                        n_cmd.emit_hdr = 1'b1;
                    end else begin
                        n_cmd.take_word = 1'b1;
                        if (i_status.last_word) begin
                            if (i_status.chk_fail) begin
                                n_cmd.emit_chk = 1'b1;
                            end else begin
                                n_cmd.row_read = 1'b1;
                                n_state        = S_SCAN;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_cmd.emit_stall = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_status.scan_free) begin
                    n_cmd.emit_ok = 1'b1;
                    n_state       = S_COPY;
                end else begin
                    n_cmd.scan_inc = 1'b1;
                end
            end
            S_COPY: begin
                if (i_status.copy_done) begin
                    n_state = S_IDLE;
                end
            end
            S_REL: begin
                n_cmd.rel_write = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = n_cmd;
    assign o_busy = r_busy;

endmodule

// ===== design/prse_datapath.sv =====
// Datapath with the staging buffer, slot valid map, slot store, checks and result register.
module prse_datapath #(
    parameter int NUM_CUBES      = prse_pkg::NUM_CUBES_DEF,
    parameter int LINKS_PER_CUBE = prse_pkg::LINKS_PER_CUBE_DEF,
    parameter int QUEUE_DEPTH    = prse_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_WORDS      = prse_pkg::MAX_WORDS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  prse_pkg::t_in_beat                   i_in,
    input  logic                                 i_cfg_we,
    input  logic [prse_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [prse_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  prse_pkg::t_ctrl_cmd                  i_cmd,
    output prse_pkg::t_dp_status                 o_status,
    output logic                                 o_res_valid,
    output prse_pkg::t_res_beat                  o_res
);
    import prse_pkg::*;

    localparam int NUM_QUEUES = NUM_CUBES * LINKS_PER_CUBE;
    localparam int NUM_SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW  = $clog2(MAX_WORDS);
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int GW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int STW = $clog2(NUM_SLOTS * MAX_WORDS);

    // Configuration registers.
    logic [3:0]  r_qdu;
    logic [63:0] r_mask;

    // Packet staging state.
    logic [4:0]  r_word_count;
    logic [4:0]  r_expected;
    logic [5:0]  r_cube;
    logic [63:0] staging [MAX_WORDS];

    // Slot valid map: one row per queue, with a row valid flag cleared at reset.
    logic [QUEUE_DEPTH-1:0] vmem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]  r_row_valid;
    logic [QUEUE_DEPTH-1:0] r_row_q;
    logic                   r_row_ok;
    logic [QW-1:0]          r_queue;
    logic [2:0]             r_rel_slot;
    logic [CW-1:0]          r_scan;

    // Link id held from the tail for search results.
    logic [2:0] r_res_link_hold;

    // Slot store and copy engine.
    logic [63:0]   sstore [NUM_SLOTS * MAX_WORDS];
    logic [GW-1:0] r_gslot;
    logic [AW-1:0] r_copy_w;
    logic          r_copy_on;
    logic [AW-1:0] r_cp_w;
    logic          r_cp_v;
    logic [63:0]   r_stage_q;

    // Result register.
    logic      r_res_v;
    t_res_beat r_res;
    t_res_beat n_res;
    logic      any_emit;

    logic                   hdr;
    logic [3:0]             flits;
    logic [4:0]             words;
    logic                   hdr_bad;
    logic [4:0]             exp_eff;
    logic                   last_word;
    logic [2:0]             link_in;
    logic                   cube_bad;
    logic                   link_bad;
    logic [1:0]             chk_code;
    logic                   rel_ok;
    logic [9:0]             q_pkt_full;
    logic [9:0]             q_rel_full;
    logic [QW-1:0]          q_sel;
    logic [QUEUE_DEPTH-1:0] row;
    logic [7:0]             depth8;
    logic                   scan_end;
    logic                   scan_free;
    logic                   copy_done;
    logic [STW-1:0]         st_addr;

    // Header decode and end of packet detection.
    always_comb begin
        hdr       = (r_word_count == 5'd0);
        flits     = i_in.word[HDR_FLIT_MSB:HDR_FLIT_LSB];
        words     = {flits, 1'b0};
        hdr_bad   = hdr && ((flits == 4'd0) || (6'(words) > 6'(MAX_WORDS)));
        exp_eff   = hdr ? words : r_expected;
        last_word = (6'(r_word_count) + 6'd1) >= 6'(exp_eff);
    end

    // Cube and link checks against the tail word now arriving.
    always_comb begin
        link_in  = i_in.word[TAIL_LINK_MSB:TAIL_LINK_LSB];
        cube_bad = 7'(r_cube) >= 7'(NUM_CUBES);
        link_bad = (4'(link_in) >= 4'(LINKS_PER_CUBE)) || (r_cube[5:3] != 3'd0) ||
                   !r_mask[{r_cube[2:0], link_in}];
        if (cube_bad) begin
            chk_code = STATUS_BAD;
        end else if (link_bad) begin
            chk_code = STATUS_NOT_HOST;
        end else begin
            chk_code = STATUS_ACCEPTED;
        end
        rel_ok = (7'(i_in.release_cube) < 7'(NUM_CUBES)) &&
                 (4'(i_in.release_link) < 4'(LINKS_PER_CUBE)) &&
                 (7'(i_in.release_slot) < 7'(QUEUE_DEPTH));
    end

    // Queue index of the packet or of the release.
    always_comb begin
        q_pkt_full = 10'(r_cube) * 10'(LINKS_PER_CUBE) + 10'(link_in);
        q_rel_full = 10'(i_in.release_cube) * 10'(LINKS_PER_CUBE) + 10'(i_in.release_link);
        q_sel      = (i_in.kind == KIND_RELEASE) ? q_rel_full[QW-1:0] : q_pkt_full[QW-1:0];
    end

    // Slot search over the fetched row, one slot a cycle from slot zero.
    always_comb begin
        row       = r_row_ok ? r_row_q : '0;
        depth8    = (8'(r_qdu) > 8'(QUEUE_DEPTH)) ? 8'(QUEUE_DEPTH) : 8'(r_qdu);
        scan_end  = 8'(r_scan) >= depth8;
        scan_free = !row[r_scan[SW-1:0]];
        copy_done = r_cp_v && (r_cp_w == AW'(MAX_WORDS - 1));
        st_addr   = STW'(r_gslot) * STW'(MAX_WORDS) + STW'(r_cp_w);
    end

    // Result beat assembly.
    always_comb begin
        any_emit = i_cmd.emit_hdr | i_cmd.emit_chk | i_cmd.emit_stall | i_cmd.emit_ok;
        n_res    = '0;
        if (i_cmd.emit_hdr) begin
            n_res.status  = STATUS_BAD;
            n_res.cube_id = i_in.word[HDR_CUBE_MSB:0];
        end else if (i_cmd.emit_chk) begin
            n_res.status  = chk_code;
            n_res.cube_id = r_cube;
            n_res.link_id = link_in;
        end else begin
            n_res.status     = i_cmd.emit_ok ? STATUS_ACCEPTED : STATUS_STALL;
            n_res.cube_id    = r_cube;
            n_res.link_id    = r_res_link_hold;
            n_res.slot_index = i_cmd.emit_ok ? 3'(r_scan) : 3'd0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qdu        <= QUEUE_DEPTH_RESET;
            r_mask       <= '0;
            r_word_count <= '0;
            r_expected   <= '0;
            r_row_valid  <= '0;
            r_copy_on    <= 1'b0;
            r_cp_v       <= 1'b0;
            r_res_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_QUEUE_DEPTH: r_qdu  <= i_cfg_data[3:0];
                    CFG_HOST_MASK:   r_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take_word) begin
                r_expected   <= exp_eff;
                r_word_count <= last_word ? 5'd0 : (r_word_count + 5'd1);
            end
            if (i_cmd.emit_ok || i_cmd.rel_write) begin
                r_row_valid[r_queue] <= 1'b1;
            end
            if (i_cmd.emit_ok) begin
                r_copy_on <= 1'b1;
            end else if (r_copy_w == AW'(MAX_WORDS - 1)) begin
                r_copy_on <= 1'b0;
            end
            r_cp_v  <= r_copy_on;
            r_res_v <= any_emit;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_word && hdr) begin
            r_cube <= i_in.word[HDR_CUBE_MSB:0];
        end
        if (i_cmd.row_read || i_cmd.rel_read) begin
            r_queue <= q_sel;
        end
        if (i_cmd.row_read) begin
            r_res_link_hold <= link_in;
        end
        if (i_cmd.rel_read) begin
            r_rel_slot <= i_in.release_slot;
        end
        if (i_cmd.row_read) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + CW'(1);
        end
        if (i_cmd.emit_ok) begin
            r_gslot  <= GW'(r_queue) * GW'(QUEUE_DEPTH) + GW'(r_scan);
            r_copy_w <= '0;
        end else if (r_copy_on) begin
            r_copy_w <= r_copy_w + AW'(1);
        end
        r_cp_w <= r_copy_w;
        if (any_emit) begin
            r_res <= n_res;
        end
    end

    // Staging buffer: written one word per beat, read by the copy engine.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_word) begin
            staging[r_word_count[AW-1:0]] <= i_in.word;
        end
        r_stage_q <= staging[r_copy_w];
    end

    // Slot valid map: row read on a lookup, row write on insert or release.
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_read || i_cmd.rel_read) begin
            r_row_q  <= vmem[q_sel];
            r_row_ok <= r_row_valid[q_sel];
        end
        if (i_cmd.emit_ok) begin
            vmem[r_queue] <= row | (QUEUE_DEPTH'(1) << r_scan);
        end else if (i_cmd.rel_write) begin
            vmem[r_queue] <= row & ~(QUEUE_DEPTH'(1) << r_rel_slot);
        end
    end

    // Slot store: the staged words, then zeros to the end of the slot.
    always_ff @(posedge i_clk) begin
        if (r_cp_v) begin
            sstore[st_addr] <= (6'(r_cp_w) < 6'(r_expected)) ? r_stage_q : 64'd0;
        end
    end

    always_comb begin
        o_status.is_release = (i_in.kind == KIND_RELEASE);
        o_status.hdr_bad    = hdr_bad;
        o_status.last_word  = last_word;
        o_status.chk_fail   = cube_bad | link_bad;
        o_status.rel_ok     = rel_ok;
        o_status.scan_end   = scan_end;
        o_status.scan_free  = scan_free;
        o_status.copy_done  = copy_done;
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

endmodule

// ===== design/packet_request_slot_enqueue_core.sv =====
// Top level of the request packet slot enqueue block.
//
//  channel   handshake               payload        direction
//  input     i_start, o_busy         i_in           in, beat taken when i_start and !o_busy
//  result    o_res_valid             o_res          out, one-cycle strobe, cannot be held
//  config    i_cfg_we                i_cfg_index,   in, written at the edge with i_cfg_we
//                                    i_cfg_data
//
// Packet words are taken one per cycle while the block is not busy. The tail of a good
// packet latches the link's valid row at its own accepting edge, then probes one slot
// per cycle. On success the slot copy follows the search. A release reads the valid
// row, then writes it back. Each result is registered and shows in the cycle after its
// decision. Reset is synchronous and clears the valid map at once through per-queue row
// flags; no clearing pass is needed. Results cannot be stalled.
module packet_request_slot_enqueue_core #(
    parameter int NUM_CUBES      = prse_pkg::NUM_CUBES_DEF,
    parameter int LINKS_PER_CUBE = prse_pkg::LINKS_PER_CUBE_DEF,
    parameter int QUEUE_DEPTH    = prse_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_WORDS      = prse_pkg::MAX_WORDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  prse_pkg::t_in_beat              i_in,
    output logic                            o_res_valid,
    output prse_pkg::t_res_beat             o_res,
    input  logic                            i_cfg_we,
    input  logic [prse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prse_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import prse_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequencer.
    prse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // Storage, checks and result register.
    prse_datapath #(
        .NUM_CUBES      (NUM_CUBES),
        .LINKS_PER_CUBE (LINKS_PER_CUBE),
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .MAX_WORDS      (MAX_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

// ===== design/prse_checker.sv =====
// Port-level checker for the request slot enqueue block, with its bind statement.
module prse_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input prse_pkg::t_in_beat  i_in,
    input logic                o_res_valid,
    input prse_pkg::t_res_beat o_res
);
    import prse_pkg::*;

    // A result only follows an accepted beat or work in progress.
    a_res_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(o_busy) || $past(i_start)))
        else $error("result beat without a preceding beat or busy cycle");

    // A release beat never causes a result in the next cycle.
    a_release_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_in.kind == KIND_RELEASE)) |=> !o_res_valid)
        else $error("release beat produced a result");

    // Only an accepted packet carries a slot index.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != STATUS_ACCEPTED)) |-> (o_res.slot_index == 3'd0))
        else $error("rejected packet carries a slot index");

    // An accepted packet is followed by the slot copy, so the block is busy.
    a_copy_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == STATUS_ACCEPTED)) |-> o_busy)
        else $error("accepted packet without slot copy in progress");

endmodule

bind packet_request_slot_enqueue_core prse_checker u_prse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_in        (i_in),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
